// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the Huffman table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CHC_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("chc assertion failed");
// Next-cycle implication, disabled during reset.
`define CHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("chc assertion failed");
`else
`define CHC_ASSERT(lbl, clk, rst_n, ante, cons)
`define CHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/chc_pkg.sv =====
// Types, codes and defaults shared by the canonical Huffman table unit.
package chc_pkg;

    // Defaults for the top-level parameters
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN_DEF = 16;

    // Fixed field widths
    localparam int FUNC_W = 2;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 5;
    localparam int STAT_W = 3;
    localparam int CODE_W = 16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DECODE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STS_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STS_PARTIAL = 3'd1;
    localparam logic [STAT_W-1:0] STS_BAD     = 3'd2;
    localparam logic [STAT_W-1:0] STS_NOTABLE = 3'd3;
    localparam logic [STAT_W-1:0] STS_BADPATH = 3'd4;

    typedef enum logic [1:0] {
        PH_EMPTY   = 2'd0,
        PH_LOADING = 2'd1,
        PH_READY   = 2'd2,
        PH_BAD     = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_CLEAR, S_WRITE, S_BINIT, S_CRD, S_CUSE, S_CEND,
        S_SINGLE, S_KRAFT, S_ARD, S_AUSE, S_QRESP, S_DRESP, S_EMIT
    } t_state;

    // Source of the pending result word
    typedef enum logic [2:0] {
        RS_NONE  = 3'd0,
        RS_OK    = 3'd1,
        RS_BAD   = 3'd2,
        RS_PHASE = 3'd3,
        RS_QUERY = 3'd4,
        RS_DEC   = 3'd5,
        RS_SYM   = 3'd6
    } t_res;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              symbol_done;
        logic [SYM_W-1:0]  symbol_out;
        logic [CODE_W-1:0] code_out;
        logic [LEN_W-1:0]  code_length_out;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic clr_part;
        logic set_load;
        logic len_wr;
        logic binit;
        logic cnt_rst;
        logic scan_inc;
        logic cnt_use;
        logic kinit;
        logic kraft;
        logic single;
        logic asg;
        logic q_rd;
        logic dec;
        logic set_ready;
        logic set_bad;
        logic emit;
        t_res res;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic              in_valid;
        logic              out_free;
        logic [FUNC_W-1:0] func;
        t_phase            phase;
        logic              last;
        logic              sym_ok;
        logic              scan_last;
        logic              len_big;
        logic              total_zero;
        logic              total_one;
        logic              kraft_fail;
        logic              kraft_end;
        logic              dec_hit;
    } t_sts;

endpackage

// ===== hw/rtl/chc_in_if.sv =====
// Input channel: one request word per handshake.
interface chc_in_if;
    logic                        valid;
    logic                        ready;
    logic [chc_pkg::FUNC_W-1:0]  func;
    logic [chc_pkg::SYM_W-1:0]   symbol_index;
    logic [chc_pkg::LEN_W-1:0]   length_in;
    logic                        last_length;
    logic                        bit_in;

    modport source (output valid, func, symbol_index, length_in, last_length, bit_in,
                    input ready);
    modport sink   (input valid, func, symbol_index, length_in, last_length, bit_in,
                    output ready);
endinterface

// ===== hw/rtl/chc_out_if.sv =====
// Output channel: one result word per handshake.
interface chc_out_if;
    logic                        valid;
    logic                        ready;
    logic [chc_pkg::STAT_W-1:0]  status;
    logic                        symbol_done;
    logic [chc_pkg::SYM_W-1:0]   symbol_out;
    logic [chc_pkg::CODE_W-1:0]  code_out;
    logic [chc_pkg::LEN_W-1:0]   code_length_out;

    modport source (output valid, status, symbol_done, symbol_out, code_out,
                    code_length_out, input ready);
    modport sink   (input valid, status, symbol_done, symbol_out, code_out,
                    code_length_out, output ready);
endinterface

// ===== hw/rtl/chc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module chc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/chc_ctrl.sv =====
// Sequencer for loads, table build, decode and query.
module chc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  chc_pkg::t_sts i_sts,
    output chc_pkg::t_cmd o_cmd
);
    chc_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            chc_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) n_state = chc_pkg::S_DISP;
            end
            chc_pkg::S_DISP: begin
                unique case (i_sts.func)
                    chc_pkg::FN_LOAD: begin
                        if (i_sts.phase != chc_pkg::PH_LOADING) begin
                            o_cmd.set_load = 1'b1;
                            o_cmd.clr_part = 1'b1;
                            o_cmd.cnt_rst  = 1'b1;
                            n_state        = chc_pkg::S_CLEAR;
                        end else begin
                            n_state = chc_pkg::S_WRITE;
                        end
                    end
                    chc_pkg::FN_DECODE: begin
                        if (i_sts.phase != chc_pkg::PH_READY) begin
                            o_cmd.res = chc_pkg::RS_PHASE;
                            n_state   = chc_pkg::S_EMIT;
                        end else begin
                            o_cmd.dec = 1'b1;
                            o_cmd.res = chc_pkg::RS_DEC;
                            n_state   = i_sts.dec_hit ? chc_pkg::S_DRESP : chc_pkg::S_EMIT;
                        end
                    end
                    chc_pkg::FN_QUERY: begin
                        if (i_sts.phase != chc_pkg::PH_READY) begin
                            o_cmd.res = chc_pkg::RS_PHASE;
                            n_state   = chc_pkg::S_EMIT;
                        end else if (i_sts.sym_ok) begin
                            o_cmd.q_rd = 1'b1;
                            n_state    = chc_pkg::S_QRESP;
                        end else begin
                            o_cmd.res = chc_pkg::RS_OK;
                            n_state   = chc_pkg::S_EMIT;
                        end
                    end
                    default: begin
                        o_cmd.res = chc_pkg::RS_OK;
                        n_state   = chc_pkg::S_EMIT;
                    end
                endcase
            end
            chc_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = chc_pkg::S_WRITE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            chc_pkg::S_WRITE: begin
                o_cmd.len_wr = 1'b1;
                if (i_sts.last) begin
                    n_state = chc_pkg::S_BINIT;
                end else begin
                    o_cmd.res = chc_pkg::RS_OK;
                    n_state   = chc_pkg::S_EMIT;
                end
            end
            chc_pkg::S_BINIT: begin
                o_cmd.binit = 1'b1;
                n_state     = chc_pkg::S_CRD;
            end
            chc_pkg::S_CRD: begin
                n_state = chc_pkg::S_CUSE;
            end
            chc_pkg::S_CUSE: begin
                o_cmd.cnt_use = 1'b1;
                if (i_sts.len_big) begin
                    o_cmd.set_bad = 1'b1;
                    o_cmd.res     = chc_pkg::RS_BAD;
                    n_state       = chc_pkg::S_EMIT;
                end else if (i_sts.scan_last) begin
                    n_state = chc_pkg::S_CEND;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = chc_pkg::S_CRD;
                end
            end
            chc_pkg::S_CEND: begin
                o_cmd.kinit   = 1'b1;
                o_cmd.cnt_rst = 1'b1;
                if (i_sts.total_zero) begin
                    o_cmd.set_ready = 1'b1;
                    o_cmd.res       = chc_pkg::RS_OK;
                    n_state         = chc_pkg::S_EMIT;
                end else if (i_sts.total_one) begin
                    n_state = chc_pkg::S_SINGLE;
                end else begin
                    n_state = chc_pkg::S_KRAFT;
                end
            end
            chc_pkg::S_SINGLE: begin
                o_cmd.single    = 1'b1;
                o_cmd.set_ready = 1'b1;
                o_cmd.res       = chc_pkg::RS_OK;
                n_state         = chc_pkg::S_EMIT;
            end
            chc_pkg::S_KRAFT: begin
                o_cmd.kraft = 1'b1;
                if (i_sts.kraft_fail) begin
                    o_cmd.set_bad = 1'b1;
                    o_cmd.res     = chc_pkg::RS_BAD;
                    n_state       = chc_pkg::S_EMIT;
                end else if (i_sts.kraft_end) begin
                    n_state = chc_pkg::S_ARD;
                end
            end
            chc_pkg::S_ARD: begin
                n_state = chc_pkg::S_AUSE;
            end
            chc_pkg::S_AUSE: begin
                o_cmd.asg = 1'b1;
                if (i_sts.scan_last) begin
                    o_cmd.set_ready = 1'b1;
                    o_cmd.res       = chc_pkg::RS_OK;
                    n_state         = chc_pkg::S_EMIT;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = chc_pkg::S_ARD;
                end
            end
            chc_pkg::S_QRESP: begin
                o_cmd.res = chc_pkg::RS_QUERY;
                n_state   = chc_pkg::S_EMIT;
            end
            chc_pkg::S_DRESP: begin
                o_cmd.res = chc_pkg::RS_SYM;
                n_state   = chc_pkg::S_EMIT;
            end
            chc_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = chc_pkg::S_IDLE;
                end
            end
            default: n_state = chc_pkg::S_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/chc_dpath.sv =====
// Datapath: length, code and symbol memories, per-length tables, decoder.
module chc_dpath #(
    parameter int SYMBOL_COUNT = chc_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = chc_pkg::MAX_CODE_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    chc_in_if.sink        i_in,
    chc_out_if.source     o_out,
    input  chc_pkg::t_cmd i_cmd,
    output chc_pkg::t_sts o_sts
);
    localparam int SW = $clog2(SYMBOL_COUNT);
    localparam int CW = $clog2(SYMBOL_COUNT + 1);
    localparam int IW = $clog2(MAX_CODE_LEN + 1);
    localparam int MW = MAX_CODE_LEN;
    localparam int LW = chc_pkg::LEN_W;

    // Latched request word
    logic [chc_pkg::FUNC_W-1:0] r_func;
    logic [chc_pkg::SYM_W-1:0]  r_sym;
    logic [LW-1:0]              r_len;
    logic                       r_last;
    logic                       r_bit;

    chc_pkg::t_phase  r_phase;
    chc_pkg::t_result r_res, n_res, r_out;
    logic             r_ovalid;

    logic [MW-1:0] r_pcode;
    logic [IW-1:0] r_pdepth;

    logic [SW-1:0] r_cnt;
    logic [SW-1:0] r_lastsym;
    logic [CW-1:0] r_total;

    // Per-length tables
    logic [CW-1:0] r_count [MAX_CODE_LEN+1];
    logic [MW:0]   r_fc    [MAX_CODE_LEN+1];
    logic [CW-1:0] r_fs    [MAX_CODE_LEN+1];
    logic [CW-1:0] r_next  [MAX_CODE_LEN+1];

    // Build walk registers
    logic [CW-1:0] r_left;
    logic [IW-1:0] r_l;
    logic [MW:0]   r_code;
    logic [CW-1:0] r_slot;
    logic [CW-1:0] r_prev;

    logic          accept;
    logic          sym_ok;
    logic [SW-1:0] sym_addr;
    logic [LW-1:0] len_rd;
    logic [MW-1:0] code_rd;
    logic [SW-1:0] sort_rd;
    logic          len_nz, len_big;
    logic [IW-1:0] len_idx, idx, d;
    logic [CW-1:0] cnt_sel, fs_sel, nx_sel;
    logic [MW:0]   fc_sel;

    logic [MW-1:0] code_n;
    logic [MW:0]   code_x, off;
    logic          fail4, hit_raw, dec_hit, d_end;
    logic [SW-1:0] slot_d;
    logic [chc_pkg::STAT_W-1:0] dec_status;

    logic [CW:0]   k_t, k_cnt, k_n;
    logic          k_end, k_fail;
    logic [MW:0]   fc_new;
    logic [CW-1:0] fs_new;

    logic          asg_we;
    logic [SW-1:0] slot_a;
    logic [MW-1:0] code_a;

    logic          len_we, cs_we;
    logic [SW-1:0] len_waddr, len_raddr, cs_waddr, sort_waddr;
    logic [LW-1:0] len_wdata;
    logic [MW-1:0] code_wdata;
    logic [SW-1:0] sort_wdata;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = i_cmd.in_ready;
    assign sym_ok     = 32'(r_sym) < SYMBOL_COUNT;
    assign sym_addr   = SW'(r_sym);

    // Shared table index: build walk length, decode depth
    assign len_nz  = len_rd != '0;
    assign len_big = {1'b0, len_rd} > (LW+1)'(MAX_CODE_LEN);
    assign len_idx = IW'(len_rd);
    assign d       = r_pdepth + IW'(1);

    always_comb begin
        if (i_cmd.kraft) begin
            idx = r_l;
        end else if (i_cmd.cnt_use || i_cmd.asg) begin
            idx = len_idx;
        end else begin
            idx = d;
        end
    end

    assign cnt_sel = r_count[idx];
    assign fc_sel  = r_fc[idx];
    assign fs_sel  = r_fs[idx];
    assign nx_sel  = r_next[idx];

    // One decode step
    assign code_n  = {r_pcode[MW-2:0], r_bit};
    assign code_x  = {1'b0, code_n};
    assign off     = code_x - fc_sel;
    assign hit_raw = (code_x >= fc_sel) && (off < (MW+1)'(cnt_sel));
    assign fail4   = (r_total == '0) || ((r_total == CW'(1)) && r_bit)
                   || (d > IW'(MAX_CODE_LEN));
    assign dec_hit = !fail4 && hit_raw;
    assign d_end   = d >= IW'(MAX_CODE_LEN);
    assign slot_d  = SW'(fs_sel + CW'(off));

    always_comb begin
        if (fail4) begin
            dec_status = chc_pkg::STS_BADPATH;
        end else if (hit_raw) begin
            dec_status = chc_pkg::STS_OK;
        end else if (d_end) begin
            dec_status = chc_pkg::STS_BADPATH;
        end else begin
            dec_status = chc_pkg::STS_PARTIAL;
        end
    end

    // Kraft check and first code / first slot per length
    assign k_t    = {r_left, 1'b0};
    assign k_cnt  = {1'b0, cnt_sel};
    assign k_n    = k_t - k_cnt;
    assign k_end  = r_l == IW'(MAX_CODE_LEN);
    assign k_fail = (k_t < k_cnt) || (k_n > (CW+1)'(SYMBOL_COUNT)) || (k_end && (k_n != '0));
    assign fc_new = (r_code + (MW+1)'(r_prev)) << 1;
    assign fs_new = r_slot + r_prev;

    // Code assignment for one symbol
    assign asg_we = i_cmd.asg && len_nz;
    assign slot_a = SW'(fs_sel + nx_sel);
    assign code_a = MW'(fc_sel + (MW+1)'(nx_sel));

    // Memory port selection
    always_comb begin
        len_we     = i_cmd.clr_wr || (i_cmd.len_wr && sym_ok) || i_cmd.single;
        len_waddr  = sym_addr;
        len_wdata  = r_len;
        if (i_cmd.clr_wr) begin
            len_waddr = r_cnt;
            len_wdata = '0;
        end else if (i_cmd.single) begin
            len_waddr = r_lastsym;
            len_wdata = LW'(1);
        end
        len_raddr  = i_cmd.q_rd ? sym_addr : r_cnt;
        cs_we      = asg_we || i_cmd.single;
        cs_waddr   = i_cmd.single ? r_lastsym : r_cnt;
        code_wdata = i_cmd.single ? '0 : code_a;
        sort_waddr = i_cmd.single ? '0 : slot_a;
        sort_wdata = i_cmd.single ? r_lastsym : r_cnt;
    end

    chc_ram #(.WIDTH(LW), .DEPTH(SYMBOL_COUNT)) u_len_ram (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(len_waddr), .i_wdata(len_wdata),
        .i_raddr(len_raddr), .o_rdata(len_rd)
    );

    chc_ram #(.WIDTH(MW), .DEPTH(SYMBOL_COUNT)) u_code_ram (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_waddr), .i_wdata(code_wdata),
        .i_raddr(sym_addr), .o_rdata(code_rd)
    );

    chc_ram #(.WIDTH(SW), .DEPTH(SYMBOL_COUNT)) u_sort_ram (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(sort_waddr), .i_wdata(sort_wdata),
        .i_raddr(slot_d), .o_rdata(sort_rd)
    );

    // Control state: phase, partial code, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= chc_pkg::PH_EMPTY;
            r_ovalid <= 1'b0;
            r_pcode  <= '0;
            r_pdepth <= '0;
        end else begin
            if (i_cmd.set_load) begin
                r_phase <= chc_pkg::PH_LOADING;
            end else if (i_cmd.set_ready) begin
                r_phase <= chc_pkg::PH_READY;
            end else if (i_cmd.set_bad) begin
                r_phase <= chc_pkg::PH_BAD;
            end
            if (i_cmd.clr_part || i_cmd.binit) begin
                r_pcode  <= '0;
                r_pdepth <= '0;
            end else if (i_cmd.dec) begin
                if (fail4 || hit_raw || d_end) begin
                    r_pcode  <= '0;
                    r_pdepth <= '0;
                end else begin
                    r_pcode  <= code_n;
                    r_pdepth <= d;
                end
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Pending result word, next value
    always_comb begin
        n_res = r_res;
        unique case (i_cmd.res)
            chc_pkg::RS_NONE: ;
            chc_pkg::RS_OK: n_res = '0;
            chc_pkg::RS_BAD: begin
                n_res        = '0;
                n_res.status = chc_pkg::STS_BAD;
            end
            chc_pkg::RS_PHASE: begin
                n_res        = '0;
                n_res.status = (r_phase == chc_pkg::PH_BAD) ? chc_pkg::STS_BAD
                                                             : chc_pkg::STS_NOTABLE;
            end
            chc_pkg::RS_QUERY: begin
                n_res                 = '0;
                n_res.code_out        = len_nz ? chc_pkg::CODE_W'(code_rd) : '0;
                n_res.code_length_out = len_rd;
            end
            chc_pkg::RS_DEC: begin
                n_res        = '0;
                n_res.status = dec_status;
            end
            chc_pkg::RS_SYM: begin
                n_res             = '0;
                n_res.symbol_done = 1'b1;
                n_res.symbol_out  = chc_pkg::SYM_W'(sort_rd);
            end
            default: ;
        endcase
    end

    // Payload and build registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_in.func;
            r_sym  <= i_in.symbol_index;
            r_len  <= i_in.length_in;
            r_last <= i_in.last_length;
            r_bit  <= i_in.bit_in;
        end

        if (i_cmd.cnt_rst || i_cmd.binit) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_inc) begin
            r_cnt <= r_cnt + SW'(1);
        end

        if (i_cmd.binit) begin
            for (int i = 0; i <= MAX_CODE_LEN; i++) begin
                r_count[i] <= '0;
                r_fc[i]    <= '0;
                r_fs[i]    <= '0;
                r_next[i]  <= '0;
            end
            r_total <= '0;
        end else if (i_cmd.cnt_use && !len_big && len_nz) begin
            r_count[len_idx] <= cnt_sel + CW'(1);
            r_total          <= r_total + CW'(1);
            r_lastsym        <= r_cnt;
        end else if (i_cmd.single) begin
            for (int i = 0; i <= MAX_CODE_LEN; i++) begin
                r_count[i] <= (i == 1) ? CW'(1) : '0;
            end
        end else if (i_cmd.kraft) begin
            r_fc[r_l] <= fc_new;
            r_fs[r_l] <= fs_new;
        end else if (asg_we) begin
            r_next[len_idx] <= nx_sel + CW'(1);
        end

        if (i_cmd.kinit) begin
            r_left <= CW'(1);
            r_l    <= IW'(1);
            r_code <= '0;
            r_slot <= '0;
            r_prev <= '0;
        end else if (i_cmd.kraft) begin
            r_left <= CW'(k_n);
            r_l    <= r_l + IW'(1);
            r_code <= fc_new;
            r_slot <= fs_new;
            r_prev <= cnt_sel;
        end

        r_res <= n_res;

        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    // Output channel
    assign o_out.valid           = r_ovalid;
    assign o_out.status          = r_out.status;
    assign o_out.symbol_done     = r_out.symbol_done;
    assign o_out.symbol_out      = r_out.symbol_out;
    assign o_out.code_out        = r_out.code_out;
    assign o_out.code_length_out = r_out.code_length_out;

    // Status to controller
    assign o_sts.in_valid   = i_in.valid;
    assign o_sts.out_free   = !r_ovalid || o_out.ready;
    assign o_sts.func       = r_func;
    assign o_sts.phase      = r_phase;
    assign o_sts.last       = r_last;
    assign o_sts.sym_ok     = sym_ok;
    assign o_sts.scan_last  = r_cnt == SW'(SYMBOL_COUNT - 1);
    assign o_sts.len_big    = len_big;
    assign o_sts.total_zero = r_total == '0;
    assign o_sts.total_one  = r_total == CW'(1);
    assign o_sts.kraft_fail = k_fail;
    assign o_sts.kraft_end  = k_end;
    assign o_sts.dec_hit    = dec_hit;
endmodule

// ===== hw/rtl/canonical_huffman_codec_table_unit.sv =====
// Canonical Huffman table unit: length loads build the code, then bit-serial decode and
// code queries. One word is in work at a time. A decode bit that completes a code and a
// query of a symbol in range pass accept, dispatch, memory read and emit; a bit that completes
// no code, a query out of range, an unused function and any word turned away for want of a
// table pass accept, dispatch and emit, and a plain load accept, dispatch, length write and
// emit. The first load of a new table first sweeps the length memory to zero. The last load
// builds the code in two walks over the length memory, with a read step and a use step per
// symbol (its single read port and registered read set this), and one step per length
// between them for the prefix check and the first codes.
`include "assert_macros.svh"
module canonical_huffman_codec_table_unit #(
    parameter int SYMBOL_COUNT = chc_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = chc_pkg::MAX_CODE_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chc_in_if.sink    i_in,
    chc_out_if.source o_out
);
    chc_pkg::t_cmd cmd;
    chc_pkg::t_sts sts;

    chc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sts(sts), .o_cmd(cmd)
    );

    chc_dpath #(.SYMBOL_COUNT(SYMBOL_COUNT), .MAX_CODE_LEN(MAX_CODE_LEN)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .o_out(o_out),
        .i_cmd(cmd), .o_sts(sts)
    );

    // A taken word blocks further input until its result is queued
    `CHC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // A result is only moved into a free output register
    `CHC_ASSERT(a_emit_free, i_clk, i_rst_n, cmd.emit, sts.out_free)
    // Decode steps only run against a built table
    `CHC_ASSERT(a_dec_ready, i_clk, i_rst_n, cmd.dec, sts.phase == chc_pkg::PH_READY)
endmodule

// ===== sim/testbench.sv =====
// Testbench for the canonical Huffman table unit: directed table, then random tables and bit streams.
`timescale 1ns / 1ps
module testbench;

    // Directed stimulus row; typed rows carry the answer read off by hand
    typedef struct {
        logic [1:0]       fn;
        logic [7:0]       sym;
        logic [4:0]       len;
        logic             lst;
        logic             b;
        bit               typed;
        chc_pkg::t_result want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    chc_in_if  in_if ();
    chc_out_if out_if ();

    canonical_huffman_codec_table_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copy of the code table
    logic [4:0] len_mem [256];
    logic [7:0] sorted_sym [256];
    int         sym_code [256];
    int         cnt_len [18];
    int         first_code [18];
    int         first_slot [18];
    int         part_code;
    int         part_depth;
    chc_pkg::t_phase phase;

    chc_pkg::t_result pending_words [$];
    int         n_sent;
    int         n_err;
    int         cyc;

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    // Long stretch with no idling on either side
    function automatic bit quiet();
        return cyc >= 6000 && cyc < 9000;
    endfunction

    // Canonical code build; 0 flags a bad table
    function automatic bit build_code();
        int nxt [18];
        int total, last_s, l, left, code;
        total = 0; last_s = 0; left = 1; code = 0;
        for (int i = 0; i < 18; i++) begin
            cnt_len[i] = 0; first_code[i] = 0; first_slot[i] = 0; nxt[i] = 0;
        end
        part_code = 0; part_depth = 0;
        for (int s = 0; s < 256; s++) begin
            l = int'(len_mem[s]);
            if (l > 16) return 1'b0;
            if (l != 0) begin
                cnt_len[l]++; total++; last_s = s;
            end
        end
        if (total == 0) return 1'b1;
        if (total == 1) begin
            cnt_len[len_mem[last_s]] = 0;
            cnt_len[1] = 1;
            len_mem[last_s] = 5'd1;
            sorted_sym[0] = last_s[7:0];
            sym_code[last_s] = 0;
            return 1'b1;
        end
        // prefix (Kraft) check: neither over-subscribed nor incomplete
        for (l = 1; l <= 16; l++) begin
            left = left * 2 - cnt_len[l];
            if (left < 0) return 1'b0;
        end
        if (left != 0) return 1'b0;
        for (l = 1; l <= 16; l++) begin
            code = (code + cnt_len[l-1]) << 1;
            first_code[l] = code;
            first_slot[l] = first_slot[l-1] + cnt_len[l-1];
        end
        for (int s = 0; s < 256; s++) begin
            l = int'(len_mem[s]);
            if (l != 0) begin
                sym_code[s] = first_code[l] + nxt[l];
                sorted_sym[(first_slot[l] + nxt[l]) % 256] = s[7:0];
                nxt[l]++;
            end
        end
        return 1'b1;
    endfunction

    // Expected result word for one request word; updates the shadow state
    function automatic chc_pkg::t_result predict_word(logic [1:0] fn, logic [7:0] sym,
                                                      logic [4:0] ln, logic lst, logic b);
        chc_pkg::t_result r;
        int code, d, total;
        r = '0;
        if (fn == chc_pkg::FN_LOAD) begin
            if (phase != chc_pkg::PH_LOADING) begin
                foreach (len_mem[i]) len_mem[i] = '0;
                part_code = 0; part_depth = 0;
                phase = chc_pkg::PH_LOADING;
            end
            len_mem[sym] = ln;
            if (lst) begin
                if (build_code()) phase = chc_pkg::PH_READY;
                else begin
                    phase = chc_pkg::PH_BAD;
                    r.status = chc_pkg::STS_BAD;
                end
            end
            return r;
        end
        if (fn == chc_pkg::FN_NONE) return r;
        if (phase != chc_pkg::PH_READY) begin
            r.status = (phase == chc_pkg::PH_BAD) ? chc_pkg::STS_BAD : chc_pkg::STS_NOTABLE;
            return r;
        end
        if (fn == chc_pkg::FN_QUERY) begin
            if (len_mem[sym] != 0) begin
                r.code_out = sym_code[sym][15:0];
                r.code_length_out = len_mem[sym];
            end
            return r;
        end
        // one decode bit
        code = (part_code << 1) | int'(b);
        d = part_depth + 1;
        total = 0;
        for (int l = 1; l <= 16; l++) total += cnt_len[l];
        if (total == 0 || (total == 1 && b) || d > 16) begin
            part_code = 0; part_depth = 0;
            r.status = chc_pkg::STS_BADPATH;
        end else if (code >= first_code[d] && code - first_code[d] < cnt_len[d]) begin
            r.symbol_done = 1'b1;
            r.symbol_out = sorted_sym[(first_slot[d] + code - first_code[d]) % 256];
            part_code = 0; part_depth = 0;
        end else if (d >= 16) begin
            part_code = 0; part_depth = 0;
            r.status = chc_pkg::STS_BADPATH;
        end else begin
            part_code = code; part_depth = d;
            r.status = chc_pkg::STS_PARTIAL;
        end
        return r;
    endfunction

    // Offer one word, wait for acceptance, queue its expected result
    task automatic send(logic [1:0] fn, logic [7:0] sym, logic [4:0] ln, logic lst,
                        logic b, bit typed = 0, chc_pkg::t_result want = '0);
        bit hs;
        chc_pkg::t_result p;
        if (!quiet() && $urandom_range(0, 99) < 26) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.func         <= fn;
        in_if.symbol_index <= sym;
        in_if.length_in    <= ln;
        in_if.last_length  <= lst;
        in_if.bit_in       <= b;
        do begin
            @(negedge i_clk);
            hs = in_if.ready;
            @(posedge i_clk);
        end while (!hs);
        p = predict_word(fn, sym, ln, lst, b);
        pending_words.insert(pending_words.size(), typed ? want : p);
        n_sent++;
    endtask

    function automatic t_row mk(logic [1:0] fn, logic [7:0] sym, logic [4:0] ln, logic lst,
                                logic b, bit typed = 0, logic [2:0] st = chc_pkg::STS_OK,
                                logic dn = 0, logic [7:0] so = 0, logic [15:0] co = 0,
                                logic [4:0] cl = 0);
        t_row r;
        r.fn = fn; r.sym = sym; r.len = ln; r.lst = lst; r.b = b; r.typed = typed;
        r.want = '{status: st, symbol_done: dn, symbol_out: so, code_out: co,
                   code_length_out: cl};
        return r;
    endfunction

    // One random table followed by decodes and queries against it
    task automatic random_table();
        int lens [$];
        int syms [256];
        int n, k, t, kind, pick, l;
        for (int i = 0; i < 256; i++) syms[i] = i;
        syms.shuffle();
        kind = $urandom_range(0, 99);
        if (kind < 78) begin
            // complete code: split leaves of a two-leaf tree
            lens = '{1, 1};
            n = $urandom_range(0, 30);
            pick = 0;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 2) != 0) pick = $urandom_range(0, lens.size() - 1);
                else pick = lens.size() - 1;
                if (lens[pick] < 16) begin
                    l = lens[pick];
                    lens.delete(pick);
                    lens.insert(lens.size(), l + 1);
                    lens.insert(lens.size(), l + 1);
                end
            end
        end else if (kind < 90) begin
            n = $urandom_range(2, 6);
            for (int i = 0; i < n; i++)
                lens.insert(lens.size(), $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                                   : $urandom_range(1, 4));
        end else if (kind < 96) begin
            lens.insert(lens.size(), $urandom_range(1, 31));
        end else begin
            lens.insert(lens.size(), 0);
        end
        lens.shuffle();
        for (int i = 0; i < lens.size(); i++) begin
            // noise while loading: absent symbols and requests with no table
            if (i > 0 && $urandom_range(0, 9) == 0)
                send(2'($urandom_range(1, 2)), 8'($urandom), 5'($urandom), 1'($urandom),
                     1'($urandom));
            if ($urandom_range(0, 9) == 0 && lens.size() < 200)
                send(chc_pkg::FN_LOAD, 8'(syms[255 - i]), 5'd0, 1'b0, 1'($urandom));
            send(chc_pkg::FN_LOAD, 8'(syms[i]), 5'(lens[i]), i == lens.size() - 1,
                 1'($urandom));
        end
        n = $urandom_range(10, 40);
        for (int j = 0; j < n; j++) begin
            t = $urandom_range(0, 99);
            if (t < 70) begin
                k = syms[$urandom_range(0, lens.size() - 1)];
                l = int'(len_mem[k]);
                if (phase == chc_pkg::PH_READY && l != 0) begin
                    for (int q = l - 1; q >= 0; q--)
                        send(chc_pkg::FN_DECODE, 8'($urandom), 5'($urandom), 1'($urandom),
                             sym_code[k][q]);
                end else
                    send(chc_pkg::FN_DECODE, 8'($urandom), 5'($urandom), 1'($urandom),
                         1'($urandom));
            end else if (t < 85)
                send(chc_pkg::FN_QUERY,
                     $urandom_range(0, 1) ? 8'(syms[$urandom_range(0, lens.size() - 1)])
                                          : 8'($urandom),
                     5'($urandom), 1'($urandom), 1'($urandom));
            else if (t < 95)
                send(chc_pkg::FN_DECODE, 8'($urandom), 5'($urandom), 1'($urandom),
                     1'($urandom));
            else
                send(chc_pkg::FN_NONE, 8'($urandom), 5'($urandom), 1'($urandom),
                     1'($urandom));
        end
    endtask

    // Result side: random stalls, one long counted hold-off
    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (cyc >= 3000 && cyc < 3400) out_if.ready <= 1'b0;
            else if (quiet()) out_if.ready <= 1'b1;
            else out_if.ready <= ($urandom_range(0, 99) >= 26);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(negedge i_clk) begin
        chc_pkg::t_result got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{status: out_if.status, symbol_done: out_if.symbol_done,
                    symbol_out: out_if.symbol_out, code_out: out_if.code_out,
                    code_length_out: out_if.code_length_out};
            if (pending_words.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result word %p", got);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10) $display("mismatch: want %p got %p", want, got);
                end
            end
        end
    end

    // Run limit
    initial begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_row plan [$];
        bit paused;
        paused = 0;
        n_sent = 0; n_err = 0; cyc = 0;
        foreach (len_mem[i]) begin
            len_mem[i] = '0; sorted_sym[i] = '0; sym_code[i] = 0;
        end
        foreach (cnt_len[i]) begin
            cnt_len[i] = 0; first_code[i] = 0; first_slot[i] = 0;
        end
        part_code = 0; part_depth = 0; phase = chc_pkg::PH_EMPTY;
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.func         <= chc_pkg::FN_NONE;
        in_if.symbol_index <= '0;
        in_if.length_in    <= '0;
        in_if.last_length  <= 1'b0;
        in_if.bit_in       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no table yet, unused func
        plan.insert(plan.size(), mk(chc_pkg::FN_DECODE, 8'd0, 5'd0, 1'b0, 1'b1, 1,
                                    chc_pkg::STS_NOTABLE));
        plan.insert(plan.size(), mk(chc_pkg::FN_QUERY, 8'd255, 5'd31, 1'b1, 1'b0, 1,
                                    chc_pkg::STS_NOTABLE));
        plan.insert(plan.size(), mk(chc_pkg::FN_NONE, 8'd255, 5'd31, 1'b1, 1'b1, 1,
                                    chc_pkg::STS_OK));
        // two one-bit codes at the symbol extremes
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd0, 5'd1, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_OK));
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd255, 5'd1, 1'b1, 1'b1, 1,
                                    chc_pkg::STS_OK));
        plan.insert(plan.size(), mk(chc_pkg::FN_DECODE, 8'd0, 5'd0, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_OK, 1, 8'd0));
        plan.insert(plan.size(), mk(chc_pkg::FN_DECODE, 8'd0, 5'd0, 1'b0, 1'b1, 1,
                                    chc_pkg::STS_OK, 1, 8'd255));
        plan.insert(plan.size(), mk(chc_pkg::FN_QUERY, 8'd255, 5'd0, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_OK, 0, 0, 16'd1, 5'd1));
        plan.insert(plan.size(), mk(chc_pkg::FN_QUERY, 8'd7, 5'd0, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_OK));
        // length too large, then requests against a bad table
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd3, 5'd17, 1'b1, 1'b0, 1,
                                    chc_pkg::STS_BAD));
        plan.insert(plan.size(), mk(chc_pkg::FN_DECODE, 8'd0, 5'd0, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_BAD));
        plan.insert(plan.size(), mk(chc_pkg::FN_QUERY, 8'd3, 5'd0, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_BAD));
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd100, 5'd31, 1'b1, 1'b1, 1,
                                    chc_pkg::STS_BAD));
        // empty table
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd5, 5'd0, 1'b1, 1'b0, 1,
                                    chc_pkg::STS_OK));
        plan.insert(plan.size(), mk(chc_pkg::FN_DECODE, 8'd0, 5'd0, 1'b0, 1'b1, 1,
                                    chc_pkg::STS_BADPATH));
        // single symbol becomes code 0 of length 1
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd9, 5'd16, 1'b1, 1'b0, 1,
                                    chc_pkg::STS_OK));
        plan.insert(plan.size(), mk(chc_pkg::FN_QUERY, 8'd9, 5'd0, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_OK, 0, 0, 16'd0, 5'd1));
        plan.insert(plan.size(), mk(chc_pkg::FN_DECODE, 8'd0, 5'd0, 1'b0, 1'b1, 1,
                                    chc_pkg::STS_BADPATH));
        plan.insert(plan.size(), mk(chc_pkg::FN_DECODE, 8'd0, 5'd0, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_OK, 1, 8'd9));
        // over-subscribed
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd1, 5'd1, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_OK));
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd2, 5'd1, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_OK));
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd3, 5'd1, 1'b1, 1'b0, 1,
                                    chc_pkg::STS_BAD));
        // incomplete
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd0, 5'd2, 1'b0, 1'b0, 1,
                                    chc_pkg::STS_OK));
        plan.insert(plan.size(), mk(chc_pkg::FN_LOAD, 8'd1, 5'd2, 1'b1, 1'b0, 1,
                                    chc_pkg::STS_BAD));
        foreach (plan[i])
            send(plan[i].fn, plan[i].sym, plan[i].len, plan[i].lst, plan[i].b,
                 plan[i].typed, plan[i].want);

        while (n_sent < 1200) begin
            random_table();
            // let the block drain completely once
            if (!paused && n_sent >= 600) begin
                paused = 1;
                in_if.valid <= 1'b0;
                wait (pending_words.size() == 0);
                @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (50) @(posedge i_clk);
        if (n_err == 0 && pending_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/chc_pkg.sv
hw/rtl/chc_in_if.sv
hw/rtl/chc_out_if.sv
hw/rtl/chc_ram.sv
hw/rtl/chc_ctrl.sv
hw/rtl/chc_dpath.sv
hw/rtl/canonical_huffman_codec_table_unit.sv
sim/testbench.sv
